/* rtl/handheld_console_timer_assert.svh */
// Assertion macros shared by the timer's checker.
`ifndef HANDHELD_CONSOLE_TIMER_ASSERT_SVH
`define HANDHELD_CONSOLE_TIMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, checked outside reset.
`define HCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* rtl/hct_pkg.sv */
// Shared types, codes and helpers of the handheld console timer.
`timescale 1ns / 1ps

package hct_pkg;

    // Command codes carried in the input beat.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Register selects.
    localparam logic [1:0] REG_DIV  = 2'd0;
    localparam logic [1:0] REG_TIMA = 2'd1;
    localparam logic [1:0] REG_TMA  = 2'd2;
    localparam logic [1:0] REG_TAC  = 2'd3;

    localparam logic [15:0] DIV_STEP = 16'd4;
    localparam int unsigned TAC_ENABLE_BIT = 2;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] reg_select;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
    } result_t;

    // Divider bit watched for a rate select: half of the period 1024, 16, 64, 256.
    function automatic logic [3:0] rate_bit(input logic [1:0] sel);
        logic [3:0] b;
        case (sel)
            2'd0:    b = 4'd9;
            2'd1:    b = 4'd3;
            2'd2:    b = 4'd5;
            2'd3:    b = 4'd7;
            default: b = 4'd9;
        endcase
        return b;
    endfunction

endpackage

/* rtl/handheld_console_timer.sv */
// Top level of the handheld console timer: stream ports, input and result registers.
`timescale 1ns / 1ps

// Handheld console timer (DIV / TIMA / TMA / TAC). Every input beat is one
// machine-cycle tick, one register write or one register read, and every
// input beat yields exactly one result beat, in order. A beat is captured in
// an input register, the timer state is updated by one short pass of logic
// (divider add, a few bit compares, one counter increment), and the result
// lands in an output register. Throughput is one beat per clock while
// m_tready is high; a beat passes the input register, then the output
// register. The output register keeps the input side moving while a result
// waits: the input stays ready unless both the input and the output
// register are full and m_tready is low.
// A result carries read_data (zero except on reads) and timer_irq, which is
// high on the tick that performs the delayed counter reload.
module handheld_console_timer (
    input  logic       aclk,
    input  logic       aresetn,
    // Input beat
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] write_data
    input  logic [3:0] s_tuser,   // [1:0] command, [3:2] reg_select
    // Result beat
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] read_data
    output logic [0:0] m_tuser    // [0] timer_irq
);

    hct_pkg::item_t   item_reg;
    logic             in_valid_reg;
    hct_pkg::result_t out_reg;
    logic             out_valid_reg;
    hct_pkg::result_t result;
    logic             advance;

    // Move the staged beat into the result register when that slot is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Hold a beat in the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.command    <= s_tuser[1:0];
            item_reg.reg_select <= s_tuser[3:2];
            item_reg.write_data <= s_tdata;
        end
    end

    // Timer state updates exactly once per beat, as it advances.
    hct_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (item_reg),
        .result  (result)
    );

    // Result register: load on advance, drop after the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_reg.read_data;
    assign m_tuser[0] = out_reg.timer_irq;

endmodule

/* rtl/hct_core.sv */
// Timer state (divider, counter, modulo, control) and its per-beat update.
`timescale 1ns / 1ps

module hct_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fire,
    input  hct_pkg::item_t  item,
    output hct_pkg::result_t result
);

    logic [15:0] div_reg, div_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic        pending_reg, pending_next;
    logic        reloaded_reg, reloaded_next;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic        enabled_reg, enabled_next;
    logic        rate_set_reg, rate_set_next;
    logic [1:0]  rate_sel_reg, rate_sel_next;
    logic [7:0]  mod_reg, mod_next;

    logic [15:0] div_plus;
    logic [3:0]  old_bit_idx;
    logic [3:0]  new_bit_idx;
    logic        old_bit;
    logic [7:0]  cnt_base;
    logic        pending_base;
    logic [1:0]  inc;
    logic [8:0]  cnt_sum;

    assign div_plus    = div_reg + hct_pkg::DIV_STEP;
    assign old_bit_idx = hct_pkg::rate_bit(rate_sel_reg);
    assign new_bit_idx = hct_pkg::rate_bit(item.write_data[1:0]);
    assign old_bit     = rate_set_reg && div_reg[old_bit_idx];

    always_comb begin
        div_next      = div_reg;
        reloaded_next = reloaded_reg;
        ctrl_next     = ctrl_reg;
        enabled_next  = enabled_reg;
        rate_set_next = rate_set_reg;
        rate_sel_next = rate_sel_reg;
        mod_next      = mod_reg;
        cnt_base      = cnt_reg;
        pending_base  = pending_reg;
        inc           = 2'd0;
        result        = '0;

        case (item.command)
            hct_pkg::CMD_TICK: begin
                reloaded_next = pending_reg;
                result.timer_irq = pending_reg;
                if (pending_reg) begin
                    cnt_base     = mod_reg;
                    pending_base = 1'b0;
                end
                div_next = div_plus;
                if (enabled_reg && rate_set_reg && div_reg[old_bit_idx]
                        && !div_plus[old_bit_idx]) begin
                    inc = 2'd1;
                end
            end
            hct_pkg::CMD_WRITE: begin
                case (item.reg_select)
                    hct_pkg::REG_DIV: begin
                        inc      = {1'b0, old_bit};
                        div_next = '0;
                    end
                    hct_pkg::REG_TIMA: begin
                        pending_base = 1'b0;
                        if (!reloaded_reg) begin
                            cnt_base = item.write_data;
                        end
                    end
                    hct_pkg::REG_TMA: begin
                        mod_next = item.write_data;
                        if (reloaded_reg) begin
                            cnt_base = item.write_data;
                        end
                    end
                    hct_pkg::REG_TAC: begin
                        // Disable with the watched bit high bumps once; a
                        // high-to-low change of the watched bit bumps again.
                        inc = 2'(enabled_reg && !item.write_data[hct_pkg::TAC_ENABLE_BIT]
                                  && old_bit)
                            + 2'(old_bit && !div_reg[new_bit_idx]);
                        ctrl_next     = item.write_data;
                        enabled_next  = item.write_data[hct_pkg::TAC_ENABLE_BIT];
                        rate_set_next = 1'b1;
                        rate_sel_next = item.write_data[1:0];
                    end
                    default: begin
                    end
                endcase
            end
            hct_pkg::CMD_READ: begin
                case (item.reg_select)
                    hct_pkg::REG_DIV:  result.read_data = div_reg[15:8];
                    hct_pkg::REG_TIMA: result.read_data = cnt_reg;
                    hct_pkg::REG_TMA:  result.read_data = mod_reg;
                    hct_pkg::REG_TAC:  result.read_data = ctrl_reg;
                    default:           result.read_data = '0;
                endcase
            end
            default: begin
            end
        endcase

        // Overflow wraps through zero and arms the delayed reload.
        cnt_sum      = {1'b0, cnt_base} + {7'd0, inc};
        cnt_next     = cnt_sum[7:0];
        pending_next = pending_base | cnt_sum[8];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg      <= '0;
            cnt_reg      <= '0;
            pending_reg  <= 1'b0;
            reloaded_reg <= 1'b0;
            ctrl_reg     <= '0;
            enabled_reg  <= 1'b0;
            rate_set_reg <= 1'b0;
            rate_sel_reg <= '0;
            mod_reg      <= '0;
        end else if (fire) begin
            div_reg      <= div_next;
            cnt_reg      <= cnt_next;
            pending_reg  <= pending_next;
            reloaded_reg <= reloaded_next;
            ctrl_reg     <= ctrl_next;
            enabled_reg  <= enabled_next;
            rate_set_reg <= rate_set_next;
            rate_sel_reg <= rate_sel_next;
            mod_reg      <= mod_next;
        end
    end

endmodule

/* rtl/hct_checker.sv */
// Port-level checks of the handheld console timer, bound to its top level.
`timescale 1ns / 1ps

`include "handheld_console_timer_assert.svh"

module hct_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic [3:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser
);

    // A stalled result beat holds.
    `HCT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // The input side stalls only behind a pending result.
    `HCT_ASSERT_NOW(a_stall_backed, !s_tready, m_tvalid)

    // An interrupt comes only from a tick, which reads nothing.
    `HCT_ASSERT_NOW(a_irq_no_data, m_tvalid && m_tuser[0], m_tdata == 8'd0)

    // With the consumer ready, the input side is never stalled.
    `HCT_ASSERT_NOW(a_ready_flow, m_tready, s_tready)

endmodule

bind handheld_console_timer hct_checker u_hct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
